>>> rtl/mh64_pkg.sv
// ----------------------------------------------------------------------------
// mh64_pkg
// Shared types and constants for the MurmurHash64A stream hasher: datapath
// command and status groups, command codes and hash constants.
// ----------------------------------------------------------------------------
package mh64_pkg;

  localparam logic [63:0] HASH_MUL   = 64'hc6a4a7935bd1e995;
  localparam int unsigned HASH_SHIFT = 47;

  // datapath command codes
  localparam logic [3:0] CMD_IDLE  = 4'd0;
  localparam logic [3:0] CMD_LOAD  = 4'd1;
  localparam logic [3:0] CMD_MUL   = 4'd2;
  localparam logic [3:0] CMD_SEED  = 4'd3;
  localparam logic [3:0] CMD_XWORD = 4'd4;
  localparam logic [3:0] CMD_XTAIL = 4'd5;
  localparam logic [3:0] CMD_XKMIX = 4'd6;
  localparam logic [3:0] CMD_XHK   = 4'd7;
  localparam logic [3:0] CMD_HP    = 4'd8;
  localparam logic [3:0] CMD_XFIN  = 4'd9;
  localparam logic [3:0] CMD_HFIN  = 4'd10;

  // partial product steps of one 64x64 (low half) multiply
  localparam logic [1:0] MUL_LO_LO = 2'd0;
  localparam logic [1:0] MUL_LO_HI = 2'd1;
  localparam logic [1:0] MUL_HI_LO = 2'd2;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] mul_step;
  } dp_cmd_t;

  typedef struct packed {
    logic len_mul;
    logic full_word;
    logic tail;
    logic last;
  } dp_status_t;

endpackage

>>> rtl/murmur_hash_64_stream.sv
// ----------------------------------------------------------------------------
// murmur_hash_64_stream
// MurmurHash64A over a message streamed as little-endian 64-bit words.
//
// Input channel (in_valid/in_ready): one word per item with its byte count
// and first/last marks; the first word also carries the start mode, total
// length and initial hash. Output channel (out_valid/out_ready): one 64-bit
// hash per message, given after the item marked last. Config: cfg_wr_en
// writes cfg_wr_data into the seed register; write only while idle.
//
// One item at a time. Every 64x64 multiply runs on one shared 32x32
// multiplier in three partial-product steps, and each item needs up to five
// of them: a full word needs three, plus one for the length multiply on a
// compute-mode first word and one for finalization on a last word; a tail
// word needs one, an empty word none.
// Result is valid the cycle after the finalization completes.
// Synchronous reset clears the seed and running hash and drops out_valid.
// If the receiver stalls, the hash holds in the output register; the next
// item is still accepted and runs, and only its finalization waits.
// ----------------------------------------------------------------------------
module murmur_hash_64_stream (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_first,
  input  logic        in_last,
  input  logic [31:0] in_total_length,
  input  logic [63:0] in_initial_hash,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_hash_value
);

  mh64_pkg::dp_cmd_t    cmd;
  mh64_pkg::dp_status_t status;

  mh64_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  mh64_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_op           (in_op),
    .in_data_word    (in_data_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_first        (in_first),
    .in_last         (in_last),
    .in_total_length (in_total_length),
    .in_initial_hash (in_initial_hash),
    .out_hash_value  (out_hash_value)
  );

endmodule

>>> rtl/mh64_dp.sv
// ----------------------------------------------------------------------------
// mh64_dp
// Hash datapath: seed register, running hash, multiply operand, a shared
// 32x32 multiplier that builds the low 64 bits of x * HASH_MUL in three
// partial-product steps, and the result register.
// ----------------------------------------------------------------------------
module mh64_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mh64_pkg::dp_cmd_t    cmd,
  output mh64_pkg::dp_status_t status,
  input  logic                 cfg_wr_en,
  input  logic [63:0]          cfg_wr_data,
  input  logic                 in_op,
  input  logic [63:0]          in_data_word,
  input  logic [3:0]           in_valid_bytes,
  input  logic                 in_first,
  input  logic                 in_last,
  input  logic [31:0]          in_total_length,
  input  logic [63:0]          in_initial_hash,
  output logic [63:0]          out_hash_value
);

  logic [63:0] seed_r;
  logic [63:0] h_r, h_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] p_r, p_nxt;
  logic [63:0] word_r;
  logic [3:0]  nb_r;
  logic        len_mul_r;
  logic        last_r;
  logic [63:0] out_r;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [63:0] tail_mask;
  logic [63:0] p_mix;
  logic [3:0]  nb_clamped;

  assign nb_clamped = (in_valid_bytes > 4'd8) ? 4'd8 : in_valid_bytes;

  assign mul_a = (cmd.mul_step == mh64_pkg::MUL_HI_LO) ? x_r[63:32] : x_r[31:0];
  assign mul_b = (cmd.mul_step == mh64_pkg::MUL_LO_HI) ?
                 mh64_pkg::HASH_MUL[63:32] : mh64_pkg::HASH_MUL[31:0];
  assign prod  = {32'd0, mul_a} * {32'd0, mul_b};

  assign p_mix = p_r ^ (p_r >> mh64_pkg::HASH_SHIFT);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      tail_mask[i*8 +: 8] = (4'(i) < nb_r) ? 8'hFF : 8'h00;
    end
  end

  always_comb begin
    h_nxt = h_r;
    x_nxt = x_r;
    p_nxt = p_r;
    case (cmd.op)
      mh64_pkg::CMD_LOAD: begin
        x_nxt = {32'd0, in_total_length};
        if (in_first && in_op) h_nxt = in_initial_hash;
      end
      mh64_pkg::CMD_MUL: begin
        if (cmd.mul_step == mh64_pkg::MUL_LO_LO) begin
          p_nxt = prod;
        end else begin
          p_nxt = {p_r[63:32] + prod[31:0], p_r[31:0]};
        end
      end
      mh64_pkg::CMD_SEED:  h_nxt = seed_r ^ p_r;
      mh64_pkg::CMD_XWORD: x_nxt = word_r;
      mh64_pkg::CMD_XTAIL: x_nxt = h_r ^ (word_r & tail_mask);
      mh64_pkg::CMD_XKMIX: x_nxt = p_mix;
      mh64_pkg::CMD_XHK:   x_nxt = h_r ^ p_r;
      mh64_pkg::CMD_HP:    h_nxt = p_r;
      mh64_pkg::CMD_XFIN:  x_nxt = h_r ^ (h_r >> mh64_pkg::HASH_SHIFT);
      mh64_pkg::CMD_HFIN:  h_nxt = p_mix;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 64'd0;
      h_r    <= 64'd0;
    end else begin
      if (cfg_wr_en) seed_r <= cfg_wr_data;
      h_r <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    p_r <= p_nxt;
    if (cmd.op == mh64_pkg::CMD_LOAD) begin
      word_r    <= in_data_word;
      nb_r      <= nb_clamped;
      len_mul_r <= in_first & ~in_op;
      last_r    <= in_last;
    end
    if (cmd.op == mh64_pkg::CMD_HFIN) out_r <= p_mix;
  end

  assign status.len_mul   = len_mul_r;
  assign status.full_word = (nb_r == 4'd8);
  assign status.tail      = (nb_r != 4'd0) && (nb_r != 4'd8);
  assign status.last      = last_r;

  assign out_hash_value = out_r;

endmodule

>>> rtl/mh64_ctrl.sv
// ----------------------------------------------------------------------------
// mh64_ctrl
// Sequencer for the hash datapath: accepts an item, steps the shared
// multiplier through each multiply of the mix and finalization, and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module mh64_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  mh64_pkg::dp_status_t status,
  output mh64_pkg::dp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_BODY   = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_POST   = 3'd4;
  localparam logic [2:0] ST_FINCHK = 3'd5;

  localparam logic [2:0] PH_LEN = 3'd0;
  localparam logic [2:0] PH_K1  = 3'd1;
  localparam logic [2:0] PH_K2  = 3'd2;
  localparam logic [2:0] PH_H   = 3'd3;
  localparam logic [2:0] PH_FIN = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [1:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = mh64_pkg::CMD_IDLE;
    cmd.mul_step  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = mh64_pkg::CMD_LOAD;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (status.len_mul) begin
          phase_nxt = PH_LEN;
          step_nxt  = mh64_pkg::MUL_LO_LO;
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_BODY;
        end
      end
      ST_BODY: begin
        step_nxt = mh64_pkg::MUL_LO_LO;
        if (status.full_word) begin
          cmd.op    = mh64_pkg::CMD_XWORD;
          phase_nxt = PH_K1;
          state_nxt = ST_MUL;
        end else if (status.tail) begin
          cmd.op    = mh64_pkg::CMD_XTAIL;
          phase_nxt = PH_H;
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_FINCHK;
        end
      end
      ST_MUL: begin
        cmd.op = mh64_pkg::CMD_MUL;
        if (step_r == mh64_pkg::MUL_HI_LO) begin
          state_nxt = ST_POST;
        end else begin
          step_nxt = step_r + 2'd1;
        end
      end
      ST_POST: begin
        step_nxt = mh64_pkg::MUL_LO_LO;
        case (phase_r)
          PH_LEN: begin
            cmd.op    = mh64_pkg::CMD_SEED;
            state_nxt = ST_BODY;
          end
          PH_K1: begin
            cmd.op    = mh64_pkg::CMD_XKMIX;
            phase_nxt = PH_K2;
            state_nxt = ST_MUL;
          end
          PH_K2: begin
            cmd.op    = mh64_pkg::CMD_XHK;
            phase_nxt = PH_H;
            state_nxt = ST_MUL;
          end
          PH_H: begin
            cmd.op    = mh64_pkg::CMD_HP;
            state_nxt = ST_FINCHK;
          end
          PH_FIN: begin
            // hold until the output register is free
            if (!out_valid_r || out_ready) begin
              cmd.op        = mh64_pkg::CMD_HFIN;
              out_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_FINCHK: begin
        step_nxt = mh64_pkg::MUL_LO_LO;
        if (status.last) begin
          cmd.op    = mh64_pkg::CMD_XFIN;
          phase_nxt = PH_FIN;
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_LEN;
      step_r      <= mh64_pkg::MUL_LO_LO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/mh64_checker.sv
// ----------------------------------------------------------------------------
// mh64_checker
// Port-level checks for the hash stream block, bound to the top level.
// ----------------------------------------------------------------------------
module mh64_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_hash_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hash_value))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready after accept");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind murmur_hash_64_stream mh64_checker u_mh64_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_hash_value (out_hash_value)
);

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for murmur_hash_64_stream
// Streams messages as 64-bit words into the hasher and checks every hash it
// returns against a cycle-free model kept alongside. Directed items cover
// the open cases, the field extremes and every byte count. Random messages
// and noise words then follow under several seeds. Both channels idle at
// random.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic        OP_SEEDED   = 1'b0;
  localparam logic        OP_CONTINUE = 1'b1;
  localparam logic [63:0] MIX_MUL     = 64'hc6a4a7935bd1e995;
  localparam int          MIX_SHIFT   = 47;
  localparam int          STALL_LIMIT = 2000;
  localparam int          SETTLE      = 40;
  localparam int          MAX_REPORTS = 10;

  typedef struct {
    logic        op;
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        first;
    logic        last;
    logic [31:0] total_length;
    logic [63:0] initial_hash;
  } word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [63:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_op;
  logic [63:0] in_data_word;
  logic [3:0]  in_valid_bytes;
  logic        in_first;
  logic        in_last;
  logic [31:0] in_total_length;
  logic [63:0] in_initial_hash;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_hash_value;

  logic [63:0] seed_copy;
  logic [63:0] hash_state;
  logic [63:0] expected_hashes[$];
  int          failures = 0;
  int          words_sent = 0;
  int          idle_cycles = 0;
  int          ready_hold = 0;
  bit          steady_flow = 1'b0;

  murmur_hash_64_stream uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_data_word    (in_data_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_first        (in_first),
    .in_last         (in_last),
    .in_total_length (in_total_length),
    .in_initial_hash (in_initial_hash),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_hash_value  (out_hash_value)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic word_t make_word(input logic op, input logic [63:0] data,
                                      input logic [3:0] nbytes, input logic first,
                                      input logic last, input logic [31:0] len,
                                      input logic [63:0] init);
    word_t w;
    w.op           = op;
    w.data_word    = data;
    w.valid_bytes  = nbytes;
    w.first        = first;
    w.last         = last;
    w.total_length = len;
    w.initial_hash = init;
    return w;
  endfunction

  // fold one accepted word into the running hash; queue the hash on a last word
  task automatic absorb_word(input word_t w);
    logic [63:0] h;
    logic [63:0] k;
    logic [63:0] mask;
    int unsigned n;
    if (w.first)
      h = (w.op == OP_SEEDED) ? (seed_copy ^ ({32'd0, w.total_length} * MIX_MUL))
                              : w.initial_hash;
    else
      h = hash_state;
    n = (w.valid_bytes > 8) ? 8 : w.valid_bytes;
    if (n == 8) begin
      k = w.data_word * MIX_MUL;
      k = k ^ (k >> MIX_SHIFT);
      k = k * MIX_MUL;
      h = (h ^ k) * MIX_MUL;
    end else if (n != 0) begin
      mask = ~64'd0 >> (64 - 8 * n);
      h = (h ^ (w.data_word & mask)) * MIX_MUL;
    end
    if (w.last) begin
      h = h ^ (h >> MIX_SHIFT);
      h = h * MIX_MUL;
      h = h ^ (h >> MIX_SHIFT);
      expected_hashes.push_back(h);
    end
    hash_state = h;
  endtask

  task automatic send_word(input word_t w);
    int gap;
    @(negedge clk);
    in_valid        <= 1'b1;
    in_op           <= w.op;
    in_data_word    <= w.data_word;
    in_valid_bytes  <= w.valid_bytes;
    in_first        <= w.first;
    in_last         <= w.last;
    in_total_length <= w.total_length;
    in_initial_hash <= w.initial_hash;
    do @(posedge clk); while (!in_ready);
    absorb_word(w);
    words_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_message(input logic op, input int unsigned len_bytes,
                              input logic [31:0] len_field);
    int unsigned words;
    int unsigned left;
    words = (len_bytes == 0) ? 1 : (len_bytes + 7) / 8;
    for (int i = 0; i < words; i++) begin
      left = len_bytes - 8 * i;
      send_word(make_word(op, rand64(), (left >= 8) ? 4'd8 : left[3:0], i == 0,
                          i == words - 1, len_field, rand64()));
    end
  endtask

  // drop valid, wait for every hash, then let the block go quiet
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_hashes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_seed(input logic [63:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    seed_copy = value;
  endtask

  task automatic test_open_cases();
    send_word(make_word(OP_SEEDED, rand64(), 4'd8, 1'b0, 1'b0, $urandom, rand64()));
    send_word(make_word(OP_SEEDED, rand64(), 4'd5, 1'b0, 1'b0, $urandom, rand64()));
    send_word(make_word(OP_CONTINUE, rand64(), 4'd0, 1'b0, 1'b1, $urandom, rand64()));
    send_word(make_word(OP_SEEDED, rand64(), 4'd8, 1'b0, 1'b1, $urandom, rand64()));
    drain();
  endtask

  task automatic test_extremes();
    write_seed(~64'd0);
    send_word(make_word(OP_SEEDED, 64'd0, 4'd0, 1'b1, 1'b1, 32'd0, 64'd0));
    send_word(make_word(OP_SEEDED, ~64'd0, 4'd8, 1'b1, 1'b1, ~32'd0, ~64'd0));
    send_word(make_word(OP_CONTINUE, 64'd0, 4'd8, 1'b1, 1'b1, ~32'd0, 64'd0));
    send_word(make_word(OP_CONTINUE, ~64'd0, 4'd7, 1'b1, 1'b1, 32'd0, ~64'd0));
    drain();
  endtask

  task automatic test_byte_counts();
    write_seed(rand64());
    for (int n = 0; n < 16; n++)
      send_word(make_word(n[0] ? OP_CONTINUE : OP_SEEDED, rand64(), n[3:0], 1'b1, 1'b1,
                          $urandom_range(0, 16), rand64()));
    drain();
  endtask

  task automatic test_random_stream(input int target, input logic [63:0] seed_value,
                                    input bit steady);
    int          start;
    int          r;
    int unsigned len;
    write_seed(seed_value);
    steady_flow = steady;
    start = words_sent;
    while (words_sent - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        repeat ($urandom_range(1, 3))
          send_word(make_word(1'($urandom_range(0, 1)), rand64(),
                              4'($urandom_range(0, 15)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              $urandom, rand64()));
      end else begin
        r = $urandom_range(0, 99);
        len = (r < 70) ? $urandom_range(0, 24) :
              (r < 95) ? $urandom_range(25, 80) : $urandom_range(81, 200);
        send_message(1'($urandom_range(0, 1)), len,
                     ($urandom_range(0, 99) < 85) ? len : $urandom);
      end
    end
    drain();
    steady_flow = 1'b0;
  endtask

  always @(negedge clk) begin
    if (steady_flow || ready_hold == 0) begin
      out_ready <= 1'b1;
      ready_hold = pick_gap();
    end else begin
      out_ready <= 1'b0;
      ready_hold = ready_hold - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_hashes.size() == 0) begin
        failures = failures + 1;
        if (failures <= MAX_REPORTS)
          $display("unexpected hash_value %h at %0t", out_hash_value, $time);
      end else begin
        if (out_hash_value !== expected_hashes[0]) begin
          failures = failures + 1;
          if (failures <= MAX_REPORTS)
            $display("hash_value mismatch: expected %h actual %h at %0t",
                     expected_hashes[0], out_hash_value, $time);
        end
        void'(expected_hashes.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = 64'd0;
    in_valid        = 1'b0;
    in_op           = OP_SEEDED;
    in_data_word    = 64'd0;
    in_valid_bytes  = 4'd0;
    in_first        = 1'b0;
    in_last         = 1'b0;
    in_total_length = 32'd0;
    in_initial_hash = 64'd0;
    out_ready       = 1'b0;
    seed_copy       = 64'd0;
    hash_state      = 64'd0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_open_cases();
    test_extremes();
    test_byte_counts();
    test_random_stream(120, 64'd0, 1'b0);
    test_random_stream(120, ~64'd0, 1'b0);
    test_random_stream(110, rand64(), 1'b1);
    test_random_stream(130, rand64(), 1'b0);

    if (failures == 0 && expected_hashes.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/mh64_pkg.sv
rtl/mh64_dp.sv
rtl/mh64_ctrl.sv
rtl/murmur_hash_64_stream.sv
rtl/mh64_checker.sv
test/testbench.sv
